// ===== hw/rtl/stream_byte_reassembler_core_assert.svh =====
// Assertion macros shared by the reassembler RTL.
`ifndef STREAM_BYTE_REASSEMBLER_CORE_ASSERT_SVH
`define STREAM_BYTE_REASSEMBLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SRB_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("srb assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define SRB_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("srb assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/srb_pkg.sv =====
package srb_pkg;

    // Default store depth and window register reset value
    localparam int unsigned CAP_DEFAULT  = 64;
    localparam logic [6:0]  WINDOW_RESET = 7'd64;
    localparam int unsigned QUEUE_DEPTH  = 2;

    // Input transaction
    typedef struct packed {
        logic [63:0] byte_position;
        logic [7:0]  byte_value;
        logic        has_byte;
        logic        ends_stream;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       run_last;
        logic       stream_closed;
        logic [6:0] held_count;
    } t_out_item;

    // Classified command passed from the front end to the back end
    typedef struct packed {
        logic [63:0] byte_position;
        logic [7:0]  byte_value;
        logic        has_byte;
        logic        ends_stream;
        logic [63:0] end_position;
    } t_cmd;

    // Back-end status seen by the top level
    typedef struct packed {
        logic       closed;
        logic       busy;
        logic [6:0] held;
    } t_srb_stat;

endpackage

// ===== hw/rtl/stream_byte_reassembler_core.sv =====
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+---------------------------
// input     | in        | i_in_valid/o_in_stall | i_in_item  (t_in_item)
// output    | out       | o_out_valid/i_out_stall | o_out_item (t_out_item)
// config    | in        | i_cfg_we              | i_cfg_wdata (window size)
//
// Back end, item with a run of n >= 1 bytes: pop, check, insert, a scan of the
// run, two finish steps, then a read state for the registered store read and a push
// state per byte; an item that emits nothing, or one arriving after close, gives one empty result.
// The front end and a 2-entry queue take new items while the back end works.
// Reset is synchronous, active low; all valid bits clear at once.
// Output stall holds the result register and pauses the emit sequence.
`include "stream_byte_reassembler_core_assert.svh"

module stream_byte_reassembler_core #(
    parameter int unsigned CAPACITY = srb_pkg::CAP_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  srb_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output srb_pkg::t_out_item o_out_item
);
    import srb_pkg::*;

    logic      w_cmd_valid;
    logic      w_q_ready;
    t_cmd      w_front_cmd;
    logic      w_q_valid;
    logic      w_q_pop;
    t_cmd      w_q_cmd;
    t_srb_stat w_stat;

    srb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_q_ready),
        .o_cmd       (w_front_cmd)
    );

    srb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_valid),
        .i_cmd   (w_front_cmd),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_cmd   (w_q_cmd)
    );

    srb_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_q_cmd     (w_q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_stat      (w_stat)
    );

    // Checks
    `SRB_ASSERT_NXT(a_closed_sticky, i_clk, i_rst_n, w_stat.closed, w_stat.closed)
    `SRB_ASSERT_IMP(a_held_bound, i_clk, i_rst_n, 1'b1, w_stat.held <= 7'(CAPACITY))
    `SRB_ASSERT_IMP(a_empty_is_last, i_clk, i_rst_n, o_out_valid && !o_out_item.out_valid, o_out_item.run_last && (o_out_item.out_byte == 8'd0))
    `SRB_ASSERT_IMP(a_closed_reported, i_clk, i_rst_n, o_out_valid && o_out_item.stream_closed && !w_stat.busy, w_stat.closed)

endmodule

// ===== hw/rtl/srb_front.sv =====
module srb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  srb_pkg::t_in_item i_in_item,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output srb_pkg::t_cmd    o_cmd
);
    import srb_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    // Classify: end position is one past a byte, or the position of a marker
    always_comb begin
        n_cmd.byte_position = i_in_item.byte_position;
        n_cmd.byte_value    = i_in_item.byte_value;
        n_cmd.has_byte      = i_in_item.has_byte;
        n_cmd.ends_stream   = i_in_item.ends_stream;
        n_cmd.end_position  = i_in_item.byte_position + 64'(i_in_item.has_byte);
    end

    assign o_in_stall  = r_valid && !i_cmd_ready;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Single holding register in front of the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
            r_cmd   <= n_cmd;
        end else if (r_valid && i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ===== hw/rtl/srb_queue.sv =====
module srb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  srb_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_pop,
    output srb_pkg::t_cmd o_cmd
);
    import srb_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/srb_back.sv =====
module srb_back #(
    parameter int unsigned CAPACITY = srb_pkg::CAP_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_wdata,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  srb_pkg::t_cmd      i_q_cmd,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output srb_pkg::t_out_item o_out_item,
    output srb_pkg::t_srb_stat o_stat
);
    import srb_pkg::*;

    localparam int unsigned SLOT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CAPACITY - 1);
    localparam logic [SLOT_W:0]   SUM_CAP   = (SLOT_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0]  CNT_CAP   = CNT_W'(CAPACITY);
    localparam logic [6:0]        CAP7      = 7'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INSERT,
        S_SCAN,
        S_FIN_ADD,
        S_FIN_CMP,
        S_EMPTY,
        S_READ,
        S_PUSH
    } t_state;

    t_state              r_state;
    logic [6:0]          r_window;
    logic [63:0]         r_next;
    logic [SLOT_W-1:0]   r_head;
    logic [CAPACITY-1:0] r_valid_bits;
    logic                r_end_known;
    logic [63:0]         r_end_pos;
    logic                r_closed;
    logic [CNT_W-1:0]    r_held;
    t_cmd                r_cmd;
    logic                r_in_win;
    logic [SLOT_W:0]     r_slot_sum;
    logic [CNT_W-1:0]    r_run;
    logic [SLOT_W-1:0]   r_scan;
    logic [7:0]          r_rd_data;
    logic                r_out_valid;
    t_out_item           r_out_item;
    logic [7:0]          r_mem [CAPACITY];

    logic [6:0]        eff_win;
    logic [63:0]       offset;
    logic              in_win;
    logic [SLOT_W:0]   n_slot_sum;
    logic [SLOT_W-1:0] ins_slot;
    logic              mem_we;
    logic              out_free;
    logic              out_load;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + 1'b1;
    endfunction

    // Window test on the offset from the next expected position
    always_comb begin
        eff_win    = (r_window > CAP7) ? CAP7 : r_window;
        offset     = r_cmd.byte_position - r_next;
        in_win     = r_cmd.has_byte && (offset[63:7] == '0) && (offset[6:0] < eff_win);
        n_slot_sum = (SLOT_W + 1)'(r_head) + (SLOT_W + 1)'(offset[SLOT_W-1:0]);
        ins_slot   = (r_slot_sum >= SUM_CAP) ? SLOT_W'(r_slot_sum - SUM_CAP)
                                             : r_slot_sum[SLOT_W-1:0];
    end

    assign mem_we   = (r_state == S_INSERT) && r_in_win && !r_valid_bits[ins_slot];
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = out_free && ((r_state == S_EMPTY) || (r_state == S_PUSH));
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_stat      = '{closed: r_closed, busy: (r_state != S_IDLE), held: 7'(r_held)};

    // Byte store: one write port, one registered read at the head slot
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[ins_slot] <= r_cmd.byte_value;
        end
        r_rd_data <= r_mem[r_head];
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window     <= WINDOW_RESET;
            r_next       <= '0;
            r_head       <= '0;
            r_valid_bits <= '0;
            r_end_known  <= 1'b0;
            r_end_pos    <= '0;
            r_closed     <= 1'b0;
            r_held       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            // result taken and no new one loaded this cycle
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd   <= i_q_cmd;
                        r_state <= r_closed ? S_EMPTY : S_CHECK;
                    end
                end
                // record the end mark, decide window membership
                S_CHECK: begin
                    if (r_cmd.ends_stream) begin
                        r_end_known <= 1'b1;
                        r_end_pos   <= r_cmd.end_position;
                    end
                    r_in_win   <= in_win;
                    r_slot_sum <= n_slot_sum;
                    r_state    <= S_INSERT;
                end
                // first copy wins
                S_INSERT: begin
                    if (mem_we) begin
                        r_valid_bits[ins_slot] <= 1'b1;
                        r_held                 <= r_held + 1'b1;
                    end
                    r_scan  <= r_head;
                    r_run   <= '0;
                    r_state <= S_SCAN;
                end
                // measure the contiguous run, one slot per cycle
                S_SCAN: begin
                    if (r_valid_bits[r_scan] && (r_run != CNT_CAP)) begin
                        r_run  <= r_run + 1'b1;
                        r_scan <= slot_inc(r_scan);
                    end else begin
                        r_state <= S_FIN_ADD;
                    end
                end
                S_FIN_ADD: begin
                    r_next  <= r_next + 64'(r_run);
                    r_held  <= r_held - r_run;
                    r_state <= S_FIN_CMP;
                end
                S_FIN_CMP: begin
                    if (r_end_known && (r_next == r_end_pos)) begin
                        r_closed <= 1'b1;
                    end
                    r_state <= (r_run == '0) ? S_EMPTY : S_READ;
                end
                // nothing emitted: one empty result
                S_EMPTY: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_item  <= '{out_byte: 8'd0, out_valid: 1'b0, run_last: 1'b1,
                                         stream_closed: r_closed, held_count: 7'(r_held)};
                        r_state     <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_state <= S_PUSH;
                end
                // hand one byte of the run to the output register
                S_PUSH: begin
                    if (out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out_item           <= '{out_byte: r_rd_data, out_valid: 1'b1,
                                                  run_last: (r_run == CNT_W'(1)),
                                                  stream_closed: r_closed,
                                                  held_count: 7'(r_held)};
                        r_valid_bits[r_head] <= 1'b0;
                        r_head               <= slot_inc(r_head);
                        r_run                <= r_run - 1'b1;
                        r_state              <= (r_run == CNT_W'(1)) ? S_IDLE : S_READ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
